/* sv/bmm_pkg.sv */
// Shared types and constants for the button to MIDI event mapper.
// No dependencies; every other file of the block imports this package.
package bmm_pkg;

    // Input command codes.
    localparam logic [2:0] CMD_PRESS    = 3'd0;
    localparam logic [2:0] CMD_RELEASE  = 3'd1;
    localparam logic [2:0] CMD_SET_PCOL = 3'd2;
    localparam logic [2:0] CMD_SET_RCOL = 3'd3;
    localparam logic [2:0] CMD_SET_NOTE = 3'd4;
    localparam logic [2:0] CMD_SET_VEL  = 3'd5;
    localparam logic [2:0] CMD_SET_MOM  = 3'd6;
    localparam logic [2:0] CMD_NONE     = 3'd7;

    // Largest accepted value for each kind of set command.
    localparam logic [7:0] COLOUR_MAX = 8'd2;
    localparam logic [7:0] LEVEL_MAX  = 8'd127;
    localparam logic [7:0] FLAG_MAX   = 8'd1;

    // USB MIDI code index numbers and MIDI status kinds.
    localparam logic [3:0] CIN_NOTE_ON  = 4'h9;
    localparam logic [3:0] CIN_NOTE_OFF = 4'h8;
    localparam logic [3:0] CIN_CONTROL  = 4'hB;
    localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
    localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
    localparam logic [7:0] STATUS_CONTROL  = 8'hB0;
    localparam logic [6:0] CONTROL_ON_VALUE  = 7'h7F;
    localparam logic [6:0] CONTROL_OFF_VALUE = 7'h00;

    // Colour code that lights the upper LED.
    localparam logic [1:0] COLOUR_ONE = 2'd1;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;

    typedef enum logic [1:0] {
        K_SET,
        K_PRESS,
        K_RELEASE
    } t_kind;

    typedef enum logic {
        BK_FIRST,
        BK_SECOND
    } t_back_state;

    // One classified item as it travels from the front to the back.
    typedef struct packed {
        t_kind      kind;
        logic       rejected;
        logic [6:0] note;
        logic [6:0] velocity;
        logic       momentary;
        logic [1:0] colour;
        logic [2:0] led_row;
        logic [2:0] led_column;
    } t_item;

    // One result beat.
    typedef struct packed {
        logic       packet_valid;
        logic [3:0] cable_header;
        logic [7:0] status_byte;
        logic [6:0] data_one;
        logic [6:0] data_two;
        logic       led_valid;
        logic       led_top;
        logic       led_bottom;
        logic [2:0] led_row;
        logic [2:0] led_column;
        logic       rejected;
        logic       last;
    } t_beat;

endpackage

/* sv/button_to_midi_event_mapper_top.sv */
// Top level of the button to MIDI event mapper: base channel register, front,
// queue and back. Depends on bmm_pkg, bmm_front, bmm_queue and bmm_back.
//
//  channel   direction  handshake              payload
//  input     in         i_in_valid/o_in_stall   i_cmd, i_button, i_value
//  result    out        o_out_valid/i_out_stall o_packet_valid .. o_last
//  config    in         i_cfg_valid/o_cfg_ready i_cfg_data (base channel)
//
// An input beat passes the front stage register, which also holds the table
// read, before it is pushed into the queue; the back then loads its first
// result beat into the output register. Momentary press and release events
// give two result beats; all other items give one. Reset is synchronous and
// clears the table, the base channel and all handshake state.
// A stalled result holds in the output register while the queue and the
// front keep taking items until the queue fills.
module button_to_midi_event_mapper_top #(
    parameter int BUTTON_COUNT   = 16,
    parameter int MATRIX_COLUMNS = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_cmd,
    input  logic [7:0] i_button,
    input  logic [7:0] i_value,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_packet_valid,
    output logic [3:0] o_cable_header,
    output logic [7:0] o_status_byte,
    output logic [6:0] o_data_one,
    output logic [6:0] o_data_two,
    output logic       o_led_valid,
    output logic       o_led_top,
    output logic       o_led_bottom,
    output logic [2:0] o_led_row,
    output logic [2:0] o_led_column,
    output logic       o_rejected,
    output logic       o_last,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [3:0] i_cfg_data
);
    import bmm_pkg::*;

    logic [3:0] r_base_channel;
    logic       push;
    logic       pop;
    logic       q_full;
    logic       q_empty;
    t_item      push_item;
    t_item      head_item;
    t_beat      beat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_channel <= 4'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_base_channel <= i_cfg_data;
        end
    end

    bmm_front #(
        .BUTTON_COUNT  (BUTTON_COUNT),
        .MATRIX_COLUMNS(MATRIX_COLUMNS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_cmd     (i_cmd),
        .i_button  (i_button),
        .i_value   (i_value),
        .i_q_full  (q_full),
        .o_push    (push),
        .o_item    (push_item)
    );

    bmm_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_item (push_item),
        .i_pop  (pop),
        .o_head (head_item),
        .o_empty(q_empty),
        .o_full (q_full)
    );

    bmm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head_item),
        .i_empty       (q_empty),
        .o_pop         (pop),
        .i_base_channel(r_base_channel),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_beat        (beat)
    );

    assign o_packet_valid = beat.packet_valid;
    assign o_cable_header = beat.cable_header;
    assign o_status_byte  = beat.status_byte;
    assign o_data_one     = beat.data_one;
    assign o_data_two     = beat.data_two;
    assign o_led_valid    = beat.led_valid;
    assign o_led_top      = beat.led_top;
    assign o_led_bottom   = beat.led_bottom;
    assign o_led_row      = beat.led_row;
    assign o_led_column   = beat.led_column;
    assign o_rejected     = beat.rejected;
    assign o_last         = beat.last;

endmodule

/* sv/bmm_front.sv */
// Front end: accepts input beats, checks set commands, owns the button table
// memories and hands classified items to the queue. Depends on bmm_pkg.
module bmm_front #(
    parameter int BUTTON_COUNT   = 16,
    parameter int MATRIX_COLUMNS = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic [2:0]    i_cmd,
    input  logic [7:0]    i_button,
    input  logic [7:0]    i_value,
    input  logic          i_q_full,
    output logic          o_push,
    output bmm_pkg::t_item o_item
);
    import bmm_pkg::*;

    localparam int BTN_W   = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
    localparam int DIV_SH  = 12;
    localparam int RECIP_W = DIV_SH + 1;
    localparam int PROD_W  = BTN_W + RECIP_W;
    localparam int MUL_W   = BTN_W + 4;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << DIV_SH) / MATRIX_COLUMNS + 1);
    localparam logic [8:0] BTN_LIMIT = 9'(BUTTON_COUNT);

    // Table storage, one memory per field so that a set can write its own field alone.
    logic [6:0] mem_note [BUTTON_COUNT];
    logic [6:0] mem_vel  [BUTTON_COUNT];
    logic       mem_mom  [BUTTON_COUNT];
    logic [1:0] mem_pcol [BUTTON_COUNT];
    logic [1:0] mem_rcol [BUTTON_COUNT];

    logic [BUTTON_COUNT-1:0] r_vld;

    logic [6:0] r_rd_note, r_rd_vel;
    logic       r_rd_mom;
    logic [1:0] r_rd_pcol, r_rd_rcol;
    logic       r_rd_ok;

    logic             r_s1_valid;
    t_kind            r_s1_kind;
    logic             r_s1_rejected;
    logic [BTN_W-1:0] r_s1_btn;
    logic [BTN_W-1:0] r_s1_row;

    logic             accept;
    logic             btn_ok;
    logic             range_ok;
    logic             is_event;
    logic             is_set;
    logic             set_ok;
    logic             fresh;
    t_kind            in_kind;
    logic [BTN_W-1:0] addr;
    logic [PROD_W-1:0] row_prod;
    logic [MUL_W-1:0] row_cols;
    logic [MUL_W-1:0] col_full;

    assign o_in_stall = r_s1_valid && i_q_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_s1_valid && !i_q_full;
    assign btn_ok     = {1'b0, i_button} < BTN_LIMIT;
    assign addr       = i_button[BTN_W-1:0];
    assign fresh      = !r_vld[addr];

    always_comb begin
        is_event = 1'b0;
        is_set   = 1'b0;
        range_ok = 1'b0;
        in_kind  = K_SET;
        unique case (i_cmd) inside
            CMD_PRESS: begin
                is_event = btn_ok;
                in_kind  = K_PRESS;
            end
            CMD_RELEASE: begin
                is_event = btn_ok;
                in_kind  = K_RELEASE;
            end
            CMD_SET_PCOL, CMD_SET_RCOL: begin
                is_set   = 1'b1;
                range_ok = i_value <= COLOUR_MAX;
            end
            CMD_SET_NOTE, CMD_SET_VEL: begin
                is_set   = 1'b1;
                range_ok = i_value <= LEVEL_MAX;
            end
            CMD_SET_MOM: begin
                is_set   = 1'b1;
                range_ok = i_value <= FLAG_MAX;
            end
            default: begin
                is_set = 1'b0;
            end
        endcase
    end

    assign set_ok = is_set && range_ok && btn_ok;

    // Row is index times a scaled reciprocal of the column count; exact for
    // indexes below 64.
    assign row_prod = PROD_W'(addr) * PROD_W'(RECIP);

    // The first write to an entry clears the fields it does not set.
    always_ff @(posedge i_clk) begin
        if (accept && set_ok) begin
            if (i_cmd == CMD_SET_NOTE) mem_note[addr] <= i_value[6:0];
            else if (fresh)            mem_note[addr] <= 7'd0;
            if (i_cmd == CMD_SET_VEL)  mem_vel[addr]  <= i_value[6:0];
            else if (fresh)            mem_vel[addr]  <= 7'd0;
            if (i_cmd == CMD_SET_MOM)  mem_mom[addr]  <= i_value[0];
            else if (fresh)            mem_mom[addr]  <= 1'b0;
            if (i_cmd == CMD_SET_PCOL) mem_pcol[addr] <= i_value[1:0];
            else if (fresh)            mem_pcol[addr] <= 2'd0;
            if (i_cmd == CMD_SET_RCOL) mem_rcol[addr] <= i_value[1:0];
            else if (fresh)            mem_rcol[addr] <= 2'd0;
        end
        if (accept && is_event) begin
            r_rd_note <= mem_note[addr];
            r_rd_vel  <= mem_vel[addr];
            r_rd_mom  <= mem_mom[addr];
            r_rd_pcol <= mem_pcol[addr];
            r_rd_rcol <= mem_rcol[addr];
            r_rd_ok   <= r_vld[addr];
        end
    end

    // An entry never written reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (accept && set_ok) begin
            r_vld[addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= is_event || is_set;
        end else if (o_push) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_kind     <= in_kind;
            r_s1_rejected <= is_set && !set_ok;
            r_s1_btn      <= addr;
            r_s1_row      <= row_prod[DIV_SH +: BTN_W];
        end
    end

    assign row_cols = MUL_W'(r_s1_row) * MUL_W'(MATRIX_COLUMNS);
    assign col_full = MUL_W'(r_s1_btn) - row_cols;

    always_comb begin
        o_item = '0;
        o_item.kind = r_s1_kind;
        if (r_s1_kind == K_SET) begin
            o_item.rejected = r_s1_rejected;
        end else begin
            o_item.note       = r_rd_ok ? r_rd_note : 7'd0;
            o_item.velocity   = r_rd_ok ? r_rd_vel : 7'd0;
            o_item.momentary  = r_rd_ok && r_rd_mom;
            o_item.led_row    = 3'(r_s1_row);
            o_item.led_column = col_full[2:0];
            if (r_s1_kind == K_PRESS) begin
                o_item.colour = r_rd_ok ? r_rd_pcol : 2'd0;
            end else begin
                o_item.colour = r_rd_ok ? r_rd_rcol : 2'd0;
            end
        end
    end

    a_unused_cmd_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_cmd == CMD_NONE |=> !r_s1_valid)
        else $error("unused command produced an item");

    a_bad_button_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_cmd == CMD_PRESS || i_cmd == CMD_RELEASE) && !btn_ok |=> !r_s1_valid)
        else $error("event on unknown button produced an item");

    a_hold_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && i_q_full |=> r_s1_valid && $stable(r_s1_kind) && $stable(r_s1_btn))
        else $error("front stage lost an item while the queue was full");

endmodule

/* sv/bmm_queue.sv */
// Short queue of classified items between the front and the back.
// Depends on bmm_pkg for the item type and depth.
module bmm_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bmm_pkg::t_item i_item,
    input  logic           i_pop,
    output bmm_pkg::t_item o_head,
    output logic           o_empty,
    output logic           o_full
);
    import bmm_pkg::*;

    t_item                  r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_PTR_W:0]   r_count;

    assign o_empty = r_count == '0;
    assign o_full  = r_count == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from an empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QUEUE_PTR_W + 1)'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

/* sv/bmm_back.sv */
// Back end: turns queued items into one or two result beats and holds the
// output register. Depends on bmm_pkg.
module bmm_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bmm_pkg::t_item i_head,
    input  logic           i_empty,
    output logic           o_pop,
    input  logic [3:0]     i_base_channel,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output bmm_pkg::t_beat o_beat
);
    import bmm_pkg::*;

    t_back_state r_state, n_state;
    t_item       r_cur;
    t_item       src;
    t_beat       r_out, n_out;
    logic        r_out_valid;
    logic        load;
    logic        out_load;
    logic [3:0]  ctrl_ch;
    logic [7:0]  status_on;
    logic [7:0]  status_off;
    logic [7:0]  status_cc;

    assign load       = !r_out_valid || !i_out_stall;
    assign ctrl_ch    = i_base_channel + 4'd1;
    assign status_on  = STATUS_NOTE_ON | {4'h0, i_base_channel};
    assign status_off = STATUS_NOTE_OFF | {4'h0, i_base_channel};
    assign status_cc  = STATUS_CONTROL | {4'h0, ctrl_ch};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_FIRST: begin
                if (load && !i_empty && i_head.kind != K_SET && i_head.momentary) begin
                    n_state = BK_SECOND;
                end
            end
            BK_SECOND: begin
                if (load) n_state = BK_FIRST;
            end
            default: n_state = BK_FIRST;
        endcase
    end

    always_comb begin
        o_pop    = 1'b0;
        out_load = 1'b0;
        src      = r_cur;
        unique case (r_state)
            BK_FIRST: begin
                o_pop    = load && !i_empty;
                out_load = o_pop;
                src      = i_head;
            end
            BK_SECOND: begin
                out_load = load;
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    // Beat contents; the LED pair rides only on the first beat of an event.
    always_comb begin
        n_out = '0;
        unique case (src.kind)
            K_SET: begin
                n_out.rejected = src.rejected;
                n_out.last     = 1'b1;
            end
            K_PRESS: begin
                n_out.packet_valid = 1'b1;
                n_out.data_one     = src.note;
                if (r_state == BK_FIRST && src.momentary) begin
                    n_out.cable_header = CIN_CONTROL;
                    n_out.status_byte  = status_cc;
                    n_out.data_two     = CONTROL_ON_VALUE;
                end else begin
                    n_out.cable_header = CIN_NOTE_ON;
                    n_out.status_byte  = status_on;
                    n_out.data_two     = src.velocity;
                    n_out.last         = 1'b1;
                end
            end
            K_RELEASE: begin
                n_out.packet_valid = 1'b1;
                n_out.data_one     = src.note;
                if (r_state == BK_FIRST) begin
                    n_out.cable_header = CIN_NOTE_OFF;
                    n_out.status_byte  = status_off;
                    n_out.data_two     = src.velocity;
                    n_out.last         = !src.momentary;
                end else begin
                    n_out.cable_header = CIN_CONTROL;
                    n_out.status_byte  = status_cc;
                    n_out.data_two     = CONTROL_OFF_VALUE;
                    n_out.last         = 1'b1;
                end
            end
            default: begin
                n_out.last = 1'b0;
            end
        endcase
        if (r_state == BK_FIRST && src.kind != K_SET) begin
            n_out.led_valid  = 1'b1;
            n_out.led_top    = src.colour == COLOUR_ONE;
            n_out.led_bottom = src.colour[1];
            n_out.led_row    = src.led_row;
            n_out.led_column = src.led_column;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_FIRST;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) r_out_valid <= out_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) r_out <= n_out;
        if (o_pop)    r_cur <= i_head;
    end

    assign o_out_valid = r_out_valid;
    assign o_beat      = r_out;

    a_second_after_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_SECOND |-> r_out_valid)
        else $error("second beat pending without a first beat shown");

    a_open_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.last |-> r_state == BK_SECOND)
        else $error("non-final beat with no second beat pending");

    a_second_needs_momentary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_SECOND |-> r_cur.momentary && r_cur.kind != K_SET)
        else $error("second beat for an item that has only one");

    a_reject_is_bare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.rejected |-> !r_out.packet_valid && !r_out.led_valid)
        else $error("rejection beat carries a packet or LED update");

endmodule

/* bench/tb_button_to_midi_event_mapper_top.sv */
// Self-checking bench for button_to_midi_event_mapper_top: directed and random
// button events and table edits, checked beat by beat against a built-in model.
// Depends on bmm_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module tb_button_to_midi_event_mapper_top;

    import bmm_pkg::*;

    localparam int BUTTON_COUNT   = 16;
    localparam int MATRIX_COLUMNS = 4;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PHASE_EVENTS   = 350;
    localparam int CYCLE_LIMIT    = 400000;

    localparam logic [1:0] COLOUR_OFF = 2'd0;
    localparam logic [1:0] COLOUR_TWO = 2'd2;
    localparam logic [7:0] COLOUR_BAD = 8'd3;

    // Mirror of the button table and base channel, plus the result beats
    // that accepted events still owe.
    class midi_event_scoreboard;
        logic [6:0] note_tab[BUTTON_COUNT];
        logic [6:0] vel_tab[BUTTON_COUNT];
        logic       mom_tab[BUTTON_COUNT];
        logic [1:0] pcol_tab[BUTTON_COUNT];
        logic [1:0] rcol_tab[BUTTON_COUNT];
        logic [3:0] base_channel;
        t_beat      expected_beats[$];
        int         failures;

        function new();
            for (int i = 0; i < BUTTON_COUNT; i++) begin
                note_tab[i] = '0;
                vel_tab[i]  = '0;
                mom_tab[i]  = 1'b0;
                pcol_tab[i] = COLOUR_OFF;
                rcol_tab[i] = COLOUR_OFF;
            end
            base_channel = '0;
            failures     = 0;
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        function t_beat make_packet(logic [3:0] cin, logic [7:0] status,
                                    logic [6:0] d1, logic [6:0] d2);
            t_beat p;
            p              = '0;
            p.packet_valid = 1'b1;
            p.cable_header = cin;
            p.status_byte  = status;
            p.data_one     = d1;
            p.data_two     = d2;
            return p;
        endfunction

        // Works out the beats of one accepted event and returns their count.
        function int note_event(logic [2:0] cmd, logic [7:0] button, logic [7:0] value);
            t_beat      first;
            t_beat      second;
            t_beat      ctrl;
            t_beat      note_pkt;
            logic [3:0] ctrl_ch;
            logic [1:0] colour;
            logic [7:0] limit;
            logic       ok;
            int         b;
            first   = '0;
            second  = '0;
            ctrl_ch = base_channel + 4'd1;
            b       = button;
            case (cmd) inside
                CMD_PRESS, CMD_RELEASE: begin
                    if (b >= BUTTON_COUNT)
                        return 0;
                    if (cmd == CMD_PRESS) begin
                        colour   = pcol_tab[b];
                        ctrl     = make_packet(CIN_CONTROL, STATUS_CONTROL | {4'd0, ctrl_ch},
                                               note_tab[b], CONTROL_ON_VALUE);
                        note_pkt = make_packet(CIN_NOTE_ON,
                                               STATUS_NOTE_ON | {4'd0, base_channel},
                                               note_tab[b], vel_tab[b]);
                        if (mom_tab[b]) begin
                            first  = ctrl;
                            second = note_pkt;
                        end else begin
                            first = note_pkt;
                        end
                    end else begin
                        colour   = rcol_tab[b];
                        ctrl     = make_packet(CIN_CONTROL, STATUS_CONTROL | {4'd0, ctrl_ch},
                                               note_tab[b], CONTROL_OFF_VALUE);
                        note_pkt = make_packet(CIN_NOTE_OFF,
                                               STATUS_NOTE_OFF | {4'd0, base_channel},
                                               note_tab[b], vel_tab[b]);
                        first  = note_pkt;
                        second = ctrl;
                    end
                    first.led_valid  = 1'b1;
                    first.led_top    = (colour == COLOUR_ONE);
                    first.led_bottom = (colour >= COLOUR_TWO);
                    first.led_row    = 3'(b / MATRIX_COLUMNS);
                    first.led_column = 3'(b % MATRIX_COLUMNS);
                    if (mom_tab[b]) begin
                        second.last = 1'b1;
                        expected_beats.push_back(first);
                        expected_beats.push_back(second);
                        return 2;
                    end
                    first.last = 1'b1;
                    expected_beats.push_back(first);
                    return 1;
                end
                CMD_NONE: return 0;
                default: begin
                    case (cmd) inside
                        CMD_SET_PCOL, CMD_SET_RCOL: limit = COLOUR_MAX;
                        CMD_SET_NOTE, CMD_SET_VEL:  limit = LEVEL_MAX;
                        default:                    limit = FLAG_MAX;
                    endcase
                    ok = (value <= limit) && (b < BUTTON_COUNT);
                    if (ok) begin
                        case (cmd)
                            CMD_SET_PCOL: pcol_tab[b] = value[1:0];
                            CMD_SET_RCOL: rcol_tab[b] = value[1:0];
                            CMD_SET_NOTE: note_tab[b] = value[6:0];
                            CMD_SET_VEL:  vel_tab[b]  = value[6:0];
                            default:      mom_tab[b]  = value[0];
                        endcase
                    end
                    first.rejected = !ok;
                    first.last     = 1'b1;
                    expected_beats.push_back(first);
                    return 1;
                end
            endcase
        endfunction

        function void check_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                failures++;
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
            end
        endfunction

        function void check_beat(t_beat got);
            t_beat want;
            if (expected_beats.size() == 0) begin
                failures++;
                $display("%0t: result beat with nothing pending, expected none, actual %h",
                         $time, got);
                return;
            end
            want = expected_beats.pop_front();
            check_field("packet_valid", want.packet_valid, got.packet_valid);
            check_field("cable_header", want.cable_header, got.cable_header);
            check_field("status_byte",  want.status_byte,  got.status_byte);
            check_field("data_one",     want.data_one,     got.data_one);
            check_field("data_two",     want.data_two,     got.data_two);
            check_field("led_valid",    want.led_valid,    got.led_valid);
            check_field("led_top",      want.led_top,      got.led_top);
            check_field("led_bottom",   want.led_bottom,   got.led_bottom);
            check_field("led_row",      want.led_row,      got.led_row);
            check_field("led_column",   want.led_column,   got.led_column);
            check_field("rejected",     want.rejected,     got.rejected);
            check_field("last",         want.last,         got.last);
        endfunction
    endclass

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [2:0] i_cmd       = CMD_NONE;
    logic [7:0] i_button    = '0;
    logic [7:0] i_value     = '0;
    logic       i_out_stall = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic [3:0] i_cfg_data  = '0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic       o_packet_valid;
    logic [3:0] o_cable_header;
    logic [7:0] o_status_byte;
    logic [6:0] o_data_one;
    logic [6:0] o_data_two;
    logic       o_led_valid;
    logic       o_led_top;
    logic       o_led_bottom;
    logic [2:0] o_led_row;
    logic [2:0] o_led_column;
    logic       o_rejected;
    logic       o_last;
    logic       o_cfg_ready;

    midi_event_scoreboard sb;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int events_with_result = 0;
    int cycle_count = 0;

    button_to_midi_event_mapper_top #(
        .BUTTON_COUNT  (BUTTON_COUNT),
        .MATRIX_COLUMNS(MATRIX_COLUMNS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_button      (i_button),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_packet_valid(o_packet_valid),
        .o_cable_header(o_cable_header),
        .o_status_byte (o_status_byte),
        .o_data_one    (o_data_one),
        .o_data_two    (o_data_two),
        .o_led_valid   (o_led_valid),
        .o_led_top     (o_led_top),
        .o_led_bottom  (o_led_bottom),
        .o_led_row     (o_led_row),
        .o_led_column  (o_led_column),
        .o_rejected    (o_rejected),
        .o_last        (o_last),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Outputs are read before this edge's updates land, so the beat seen
    // here is the one the handshake actually moved.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_beat({o_packet_valid, o_cable_header, o_status_byte, o_data_one,
                           o_data_two, o_led_valid, o_led_top, o_led_bottom, o_led_row,
                           o_led_column, o_rejected, o_last});
    end

    task automatic send_event(logic [2:0] cmd, logic [7:0] button, logic [7:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_button   <= button;
        i_value    <= value;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        if (sb.note_event(cmd, button, value) > 0)
            events_with_result++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        // Ignored events owe no beat but may still be in flight.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_base_channel(logic [3:0] channel);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= channel;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        sb.base_channel = channel;
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly real press and release traffic and sane table edits; the rest
    // is any command with any button and value.
    task automatic random_event();
        logic [2:0] cmd;
        logic [7:0] button;
        logic [7:0] value;
        int         pick;
        pick   = $urandom_range(99);
        button = 8'($urandom_range(BUTTON_COUNT - 1));
        value  = '0;
        if (pick < 55) begin
            cmd = $urandom_range(1) ? CMD_RELEASE : CMD_PRESS;
        end else if (pick < 88) begin
            cmd = 3'($urandom_range(CMD_SET_MOM, CMD_SET_PCOL));
            case (cmd) inside
                CMD_SET_PCOL, CMD_SET_RCOL: value = 8'($urandom_range(COLOUR_MAX));
                CMD_SET_NOTE, CMD_SET_VEL:  value = 8'($urandom_range(LEVEL_MAX));
                default:                    value = 8'($urandom_range(FLAG_MAX));
            endcase
        end else begin
            cmd    = 3'($urandom_range(CMD_NONE));
            button = 8'($urandom_range(255));
            value  = 8'($urandom_range(255));
        end
        send_event(cmd, button, value);
    endtask

    initial begin
        int start_count;
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty table at reset: zero notes, no LEDs lit.
        send_event(CMD_PRESS, 8'd0, 8'd0);
        send_event(CMD_RELEASE, 8'd0, 8'd0);
        send_event(CMD_SET_NOTE, 8'd15, 8'd127);
        send_event(CMD_SET_VEL, 8'd15, 8'd127);
        send_event(CMD_SET_MOM, 8'd15, 8'd1);
        send_event(CMD_SET_PCOL, 8'd15, 8'd1);
        send_event(CMD_SET_RCOL, 8'd15, 8'd2);
        // Values out of range, and buttons past the table.
        send_event(CMD_SET_PCOL, 8'd3, COLOUR_BAD);
        send_event(CMD_SET_NOTE, 8'd3, 8'd128);
        send_event(CMD_SET_VEL, 8'd3, 8'd255);
        send_event(CMD_SET_MOM, 8'd3, 8'd2);
        send_event(CMD_SET_NOTE, 8'd16, 8'd5);
        send_event(CMD_SET_VEL, 8'd255, 8'd0);
        // Events that must vanish without a beat, then table edits for button 5.
        send_event(CMD_PRESS, 8'd16, 8'd0);
        send_event(CMD_RELEASE, 8'd255, 8'd255);
        send_event(CMD_NONE, 8'd255, 8'd255);
        send_event(CMD_SET_PCOL, 8'd5, 8'd2);
        send_event(CMD_SET_MOM, 8'd5, 8'd1);
        send_event(CMD_SET_NOTE, 8'd5, 8'd0);
        // Base channel 15 makes the control channel wrap to 0.
        write_base_channel(4'd15);
        send_event(CMD_PRESS, 8'd15, 8'd0);
        send_event(CMD_RELEASE, 8'd15, 8'd0);
        send_event(CMD_PRESS, 8'd5, 8'd0);
        send_event(CMD_RELEASE, 8'd5, 8'd0);
        send_event(CMD_PRESS, 8'd3, 8'd0);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    write_base_channel(4'd0);
                    send_idle_pct  = 37;
                    recv_stall_pct = 74;
                end
                1: begin
                    write_base_channel(4'd14);
                    send_idle_pct  = 74;
                    recv_stall_pct = 37;
                end
                default: begin
                    write_base_channel(4'($urandom_range(15)));
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            start_count = events_with_result;
            while (events_with_result - start_count < PHASE_EVENTS) begin
                random_event();
                if ($urandom_range(199) == 0)
                    drain_results();
            end
        end

        drain_results();
        if (sb.failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
